[hw/rtl/sma_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the sign-magnitude arithmetic unit.
// ----------------------------------------------------------------------------
package sma_pkg;

  // default word width, sign bit included
  localparam int unsigned SMA_WORD_WIDTH = 16;

  // operation codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_MUL  = 2'd1,
    CMD_DIV  = 2'd2,
    CMD_NONE = 2'd3
  } sma_cmd_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SWAP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } sma_state_e;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic     in_fire;
    sma_cmd_e cmd;
    logic     b_zero;
    logic     signs_eq;
    logic     carry;
    logic     out_free;
  } sma_status_t;

endpackage
`default_nettype wire

[hw/rtl/sma_addsub.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_addsub
// Shared adder/subtractor used by every operation step; carry out set on
// subtract means no borrow.
// ----------------------------------------------------------------------------
module sma_addsub #(
  parameter int unsigned WIDTH = 16
) (
  input  wire logic [WIDTH-1:0] x_i,
  input  wire logic [WIDTH-1:0] y_i,
  input  wire logic             sub_i,
  output logic      [WIDTH-1:0] sum_o,
  output logic                  carry_o
);

  logic [WIDTH-1:0] y_eff;
  logic [WIDTH:0]   total;

  // two's complement subtract by inverting and carrying in
  assign y_eff   = sub_i ? ~y_i : y_i;
  assign total   = {1'b0, x_i} + {1'b0, y_eff} + {{WIDTH{1'b0}}, sub_i};
  assign sum_o   = total[WIDTH-1:0];
  assign carry_o = total[WIDTH];

endmodule
`default_nettype wire

[hw/rtl/sma_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sma_seq
// Sequencer: picks the step applied to the shared adder each cycle and
// counts the bit iterations of multiply and divide.
// ----------------------------------------------------------------------------
module sma_seq
  import sma_pkg::*;
#(
  parameter int unsigned MAG_W = SMA_WORD_WIDTH - 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sma_status_t status_i,
  output sma_state_e       state_o
);

  localparam int unsigned CNT_W = $clog2(MAG_W);

  sma_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // state and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (status_i.in_fire) begin
          cnt_d = CNT_W'(MAG_W - 1);
          case (status_i.cmd)
            CMD_ADD: state_d = ST_ADD;
            CMD_MUL: state_d = ST_MUL;
            CMD_DIV: state_d = status_i.b_zero ? ST_FIN : ST_DIV;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_ADD: begin
        // opposite signs with a smaller first magnitude needs the reverse subtract
        if (!status_i.signs_eq && !status_i.carry) begin
          state_d = ST_SWAP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SWAP: state_d = ST_FIN;
      ST_MUL, ST_DIV: begin
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule
`default_nettype wire

[hw/rtl/sign_magnitude_alu_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sign_magnitude_alu_unit
// Sign-magnitude add, multiply and truncating divide on one shared adder.
//
//  channel  | direction | tdata               | tuser
//  s_axis   | in        | operand_a, operand_b | command
//  m_axis   | out       | result              | overflow, divide_by_zero
//
// An add runs ST_ADD and, for opposite signs with a smaller first magnitude,
// ST_SWAP; multiply, and divide by a nonzero divisor, take one step per
// magnitude bit through the shared adder, between accept and finish.
// s_axis_tready_o is high only while the sequencer is idle. A finished result
// sits in the output register, so the next transaction can be accepted while
// it waits. Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module sign_magnitude_alu_unit
  import sma_pkg::*;
#(
  parameter int unsigned WORD_WIDTH = SMA_WORD_WIDTH
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // operand_a [WORD_WIDTH-1:0], operand_b above it, zero padded
  input  wire logic [((2*WORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata_i,
  // command [1:0]
  input  wire logic [1:0]                            s_axis_tuser_i,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  // result [WORD_WIDTH-1:0], zero padded
  output logic      [((WORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata_o,
  // overflow [0], divide_by_zero [1]
  output logic      [1:0]                            m_axis_tuser_o,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i
);

  localparam int unsigned MAG_W  = WORD_WIDTH - 1;
  localparam int unsigned OUT_DW = ((WORD_WIDTH + 7) / 8) * 8;

  sma_state_e  state;
  sma_status_t status;

  // input decode
  logic [WORD_WIDTH-1:0] word_a, word_b;
  logic [MAG_W-1:0]      in_ma, in_mb;
  sma_cmd_e              in_cmd;
  logic                  in_fire;

  assign word_a  = s_axis_tdata_i[WORD_WIDTH-1:0];
  assign word_b  = s_axis_tdata_i[2*WORD_WIDTH-1:WORD_WIDTH];
  assign in_ma   = word_a[MAG_W-1:0];
  assign in_mb   = word_b[MAG_W-1:0];
  assign in_cmd  = sma_cmd_e'(s_axis_tuser_i);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = (state == ST_IDLE);

  // working registers
  logic [MAG_W-1:0] opa_q, opb_q, lo_q;
  logic [MAG_W:0]   acc_q;
  sma_cmd_e         cmd_q;
  logic             sa_q, sb_q, neg_q, dz_q;

  // output register
  logic              m_valid_q;
  logic [MAG_W-1:0]  m_mag_q;
  logic              m_neg_q, m_ovf_q, m_dz_q;
  logic              out_free;

  assign out_free = !m_valid_q || m_axis_tready_i;

  // shared adder operand select
  logic [MAG_W:0] add_x, add_y, add_sum, div_shift;
  logic           add_sub, add_carry;

  assign div_shift = {acc_q[MAG_W-1:0], lo_q[MAG_W-1]};

  always_comb begin
    add_x   = {1'b0, opa_q};
    add_y   = {1'b0, opb_q};
    add_sub = 1'b0;
    case (state)
      ST_ADD: begin
        add_sub = (sa_q != sb_q);
      end
      ST_SWAP: begin
        add_x   = {1'b0, opb_q};
        add_y   = {1'b0, opa_q};
        add_sub = 1'b1;
      end
      ST_MUL: begin
        add_x = acc_q;
        add_y = lo_q[0] ? {1'b0, opb_q} : '0;
      end
      ST_DIV: begin
        add_x   = div_shift;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  sma_addsub #(
    .WIDTH(MAG_W + 1)
  ) u_addsub (
    .x_i    (add_x),
    .y_i    (add_y),
    .sub_i  (add_sub),
    .sum_o  (add_sum),
    .carry_o(add_carry)
  );

  // sequencer
  assign status.in_fire  = in_fire;
  assign status.cmd      = in_cmd;
  assign status.b_zero   = (in_mb == '0);
  assign status.signs_eq = (sa_q == sb_q);
  assign status.carry    = add_carry;
  assign status.out_free = out_free;

  sma_seq #(
    .MAG_W(MAG_W)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .state_o (state)
  );

  // datapath updates per step
  always_ff @(posedge clk_i) begin
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          opa_q <= in_ma;
          opb_q <= in_mb;
          lo_q  <= in_ma;
          acc_q <= '0;
          cmd_q <= in_cmd;
          // a zero magnitude adds as plain zero
          sa_q  <= word_a[MAG_W] && !(in_cmd == CMD_ADD && in_ma == '0);
          sb_q  <= word_b[MAG_W] && !(in_cmd == CMD_ADD && in_mb == '0);
          dz_q  <= (in_cmd == CMD_DIV) && (in_mb == '0);
        end
      end
      ST_ADD: begin
        acc_q <= add_sum;
        neg_q <= sa_q;
      end
      ST_SWAP: begin
        acc_q <= add_sum;
        neg_q <= sb_q;
      end
      ST_MUL: begin
        acc_q <= {1'b0, add_sum[MAG_W:1]};
        lo_q  <= {add_sum[0], lo_q[MAG_W-1:1]};
      end
      ST_DIV: begin
        acc_q <= add_carry ? add_sum : div_shift;
        lo_q  <= {lo_q[MAG_W-2:0], add_carry};
      end
      default: ;
    endcase
  end

  // result formatting
  logic [MAG_W-1:0] fin_mag;
  logic             fin_neg, fin_ovf, fin_dz;

  always_comb begin
    fin_mag = '0;
    fin_neg = 1'b0;
    fin_ovf = 1'b0;
    fin_dz  = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        fin_ovf = acc_q[MAG_W];
        fin_mag = fin_ovf ? {MAG_W{1'b1}} : acc_q[MAG_W-1:0];
        fin_neg = neg_q && (fin_mag != '0);
      end
      CMD_MUL: begin
        fin_ovf = (acc_q[MAG_W-1:0] != '0);
        fin_mag = fin_ovf ? {MAG_W{1'b1}} : lo_q;
        fin_neg = sa_q ^ sb_q;
      end
      CMD_DIV: begin
        fin_dz = dz_q;
        if (!dz_q) begin
          fin_mag = lo_q;
          fin_neg = sa_q ^ sb_q;
        end
      end
      default: ;
    endcase
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (state == ST_FIN && out_free) begin
      m_mag_q <= fin_mag;
      m_neg_q <= fin_neg;
      m_ovf_q <= fin_ovf;
      m_dz_q  <= fin_dz;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OUT_DW'({m_neg_q, m_mag_q});
  assign m_axis_tuser_o  = {m_dz_q, m_ovf_q};

`ifndef SYNTHESIS
  // the two flags never come together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("overflow and divide_by_zero both set");

  // a zero divisor gives positive zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1]) |-> (m_axis_tdata_o == '0))
    else $error("divide by zero result not zero");

  // saturation gives the largest magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (&m_axis_tdata_o[MAG_W-1:0]))
    else $error("saturated magnitude not at maximum");

  // the unit is busy right after it takes an operand pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("ready right after accept");
`endif

endmodule
`default_nettype wire

[tb/sv/sign_magnitude_alu_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_magnitude_alu_unit_test
// Self-checking bench for the sign-magnitude add/multiply/divide unit.
// A table of corner cases runs first, then random operand pairs, all
// streamed through s_axis with random source and sink gaps and one long
// sink hold-off. Every m_axis transaction is checked against the table's own
// result, or else a local sign-magnitude calculation of the same command.
// ----------------------------------------------------------------------------
module sign_magnitude_alu_unit_test;
  import sma_pkg::*;

  localparam int W        = SMA_WORD_WIDTH;
  localparam int MB       = W - 1;
  localparam int IN_BITS  = ((2 * W + 7) / 8) * 8;
  localparam int OUT_BITS = ((W + 7) / 8) * 8;

  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM   = 1526;
  localparam int PHASE_ITEMS  = 500;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic [MB-1:0] MAG_MAX = '1;

  typedef struct packed {
    logic [W-1:0] result;
    logic         overflow;
    logic         div_zero;
  } alu_out_t;

  typedef struct packed {
    sma_cmd_e     cmd;
    logic [W-1:0] operand_a;
    logic [W-1:0] operand_b;
    logic         known;
    alu_out_t     want;
  } alu_request_t;

  typedef enum logic [1:0] {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_FREE
  } idle_phase_e;

  localparam alu_out_t NO_WANT = '0;

  logic                clk_i;
  logic                rst_ni;
  logic [IN_BITS-1:0]  s_axis_tdata_i  = '0;
  logic [1:0]          s_axis_tuser_i  = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OUT_BITS-1:0] m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;

  alu_request_t directed_rows [NUM_DIRECTED];
  alu_request_t request_list [$];
  alu_request_t pending_results [$];

  int          send_idx    = 0;
  int          error_count = 0;
  int          stall_cycles = 0;
  idle_phase_e idle_phase  = PH_SLOW_SINK;
  logic        run_done    = 1'b0;
  logic        timed_out   = 1'b0;

  sign_magnitude_alu_unit #(
    .WORD_WIDTH(W)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i)
  );

  // clock and a single reset pulse
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sign-magnitude calculation of one command
  function automatic alu_out_t predict_alu(sma_cmd_e cmd, logic [W-1:0] a, logic [W-1:0] b);
    alu_out_t      r;
    logic          sa;
    logic          sb;
    logic          neg;
    logic [MB-1:0] ma;
    logic [MB-1:0] mb;
    logic [MB+1:0] sum;
    logic [2*MB-1:0] prod;
    r   = '0;
    sa  = a[W-1];
    sb  = b[W-1];
    ma  = a[MB-1:0];
    mb  = b[MB-1:0];
    neg = 1'b0;
    case (cmd)
      CMD_ADD: begin
        // negative zero behaves as plain zero
        if (ma == '0) sa = 1'b0;
        if (mb == '0) sb = 1'b0;
        if (sa == sb) begin
          sum = {2'b00, ma} + {2'b00, mb};
          neg = sa;
        end else if (ma >= mb) begin
          sum = {2'b00, ma} - {2'b00, mb};
          neg = sa;
        end else begin
          sum = {2'b00, mb} - {2'b00, ma};
          neg = sb;
        end
        if (sum > {2'b00, MAG_MAX}) begin
          sum        = {2'b00, MAG_MAX};
          r.overflow = 1'b1;
        end
        if (sum == '0) neg = 1'b0;
        r.result = {neg, sum[MB-1:0]};
      end
      CMD_MUL: begin
        prod = {{MB{1'b0}}, ma} * {{MB{1'b0}}, mb};
        if (prod > {{MB{1'b0}}, MAG_MAX}) begin
          prod       = {{MB{1'b0}}, MAG_MAX};
          r.overflow = 1'b1;
        end
        r.result = {sa ^ sb, prod[MB-1:0]};
      end
      CMD_DIV: begin
        if (mb == '0) begin
          r.div_zero = 1'b1;
        end else begin
          r.result = {sa ^ sb, ma / mb};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // operand with a magnitude from one of several corner-heavy classes
  function automatic logic [W-1:0] random_operand();
    logic          sgn;
    logic [MB-1:0] mag;
    sgn = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0:       mag = '0;
      1:       mag = MAG_MAX;
      2:       mag = MB'($urandom_range(1, 15));
      3:       mag = MB'($urandom_range(0, 255));
      4:       mag = MAG_MAX - MB'($urandom_range(0, 15));
      default: mag = MB'($urandom);
    endcase
    return {sgn, mag};
  endfunction

  function automatic idle_phase_e phase_for(int idx);
    if (idx < NUM_DIRECTED + PHASE_ITEMS) return PH_SLOW_SINK;
    if (idx < NUM_DIRECTED + 2 * PHASE_ITEMS) return PH_SLOW_SOURCE;
    return PH_FREE;
  endfunction

  // stimulus: corner table first, then random commands
  initial begin : build_requests
    alu_request_t req;
    directed_rows = '{
      '{CMD_ADD,  16'h0000, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{CMD_ADD,  16'h8000, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{CMD_ADD,  16'h8000, 16'h8000, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{CMD_ADD,  16'h7FFF, 16'h0001, 1'b1, '{16'h7FFF, 1'b1, 1'b0}},
      '{CMD_ADD,  16'hFFFF, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b1, 1'b0}},
      '{CMD_ADD,  16'h0005, 16'h8005, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{CMD_ADD,  16'h7FFF, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{CMD_ADD,  16'h0003, 16'h8007, 1'b0, NO_WANT},
      '{CMD_ADD,  16'h8000, 16'h0007, 1'b0, NO_WANT},
      '{CMD_MUL,  16'h7FFF, 16'h0001, 1'b1, '{16'h7FFF, 1'b0, 1'b0}},
      '{CMD_MUL,  16'h7FFF, 16'h7FFF, 1'b1, '{16'h7FFF, 1'b1, 1'b0}},
      '{CMD_MUL,  16'h8000, 16'h0005, 1'b1, '{16'h8000, 1'b0, 1'b0}},
      '{CMD_MUL,  16'hFFFF, 16'hFFFF, 1'b1, '{16'h7FFF, 1'b1, 1'b0}},
      '{CMD_MUL,  16'h00B5, 16'h00B5, 1'b0, NO_WANT},
      '{CMD_MUL,  16'h00B5, 16'h80B6, 1'b0, NO_WANT},
      '{CMD_MUL,  16'h8003, 16'h0004, 1'b0, NO_WANT},
      '{CMD_DIV,  16'h7FFF, 16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
      '{CMD_DIV,  16'h8005, 16'h8000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
      '{CMD_DIV,  16'h7FFF, 16'h0001, 1'b1, '{16'h7FFF, 1'b0, 1'b0}},
      '{CMD_DIV,  16'h0003, 16'h8007, 1'b1, '{16'h8000, 1'b0, 1'b0}},
      '{CMD_DIV,  16'hFFFF, 16'h8001, 1'b1, '{16'h7FFF, 1'b0, 1'b0}},
      '{CMD_DIV,  16'h0064, 16'h8007, 1'b0, NO_WANT},
      '{CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 1'b0, 1'b0}},
      '{CMD_NONE, 16'h1234, 16'h5678, 1'b1, '{16'h0000, 1'b0, 1'b0}}
    };
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      request_list = {request_list, directed_rows[i]};
    end
    for (int i = 0; i < NUM_RANDOM; i++) begin
      req.cmd       = ($urandom_range(0, 15) == 0) ? CMD_NONE
                                                   : sma_cmd_e'(2'($urandom_range(0, 2)));
      req.operand_a = random_operand();
      req.operand_b = random_operand();
      req.known     = 1'b0;
      req.want      = NO_WANT;
      request_list  = {request_list, req};
    end
  end

  // source driver, result checker and stall watchdog
  always @(posedge clk_i) begin : stream_check
    alu_out_t           got;
    alu_out_t           exp_out;
    alu_request_t       exp_req;
    alu_request_t       req;
    logic [IN_BITS-1:0] packed_in;
    logic               progress;
    int                 send_idle;
    if (rst_ni) begin
      progress = 1'b0;

      // result transaction
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        progress     = 1'b1;
        got.result   = m_axis_tdata_o[W-1:0];
        got.overflow = m_axis_tuser_o[0];
        got.div_zero = m_axis_tuser_o[1];
        if (pending_results.size() == 0) begin
          if (error_count < 10) begin
            $display("unexpected result %h ovf %b dz %b", got.result, got.overflow,
                     got.div_zero);
          end
          error_count++;
        end else begin
          exp_req = pending_results.pop_front();
          exp_out = exp_req.want;
          if (got.result !== exp_out.result || got.overflow !== exp_out.overflow ||
              got.div_zero !== exp_out.div_zero) begin
            if (error_count < 10) begin
              $display("mismatch cmd %0d a %h b %h: exp %h ovf %b dz %b, got %h ovf %b dz %b",
                       exp_req.cmd, exp_req.operand_a, exp_req.operand_b, exp_out.result,
                       exp_out.overflow, exp_out.div_zero, got.result, got.overflow,
                       got.div_zero);
            end
            error_count++;
          end
        end
      end

      // operand transaction
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        progress = 1'b1;
        req      = request_list[send_idx];
        if (!req.known) req.want = predict_alu(req.cmd, req.operand_a, req.operand_b);
        pending_results = {pending_results, req};
        send_idx++;
      end

      // offer the next request unless the source idles this cycle
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        case (phase_for(send_idx))
          PH_SLOW_SINK:   send_idle = 24;
          PH_SLOW_SOURCE: send_idle = 60;
          default:        send_idle = 0;
        endcase
        if (send_idx < request_list.size() && $urandom_range(0, 99) >= send_idle) begin
          req                  = request_list[send_idx];
          packed_in            = '0;
          packed_in[2*W-1:0]   = {req.operand_b, req.operand_a};
          s_axis_tdata_i      <= packed_in;
          s_axis_tuser_i      <= req.cmd;
          s_axis_tvalid_i     <= 1'b1;
        end else begin
          s_axis_tvalid_i     <= 1'b0;
        end
      end

      idle_phase <= phase_for(send_idx);

      // watchdog on cycles without any transaction
      if (progress) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) timed_out <= 1'b1;

      if (send_idx == request_list.size() && pending_results.size() == 0) run_done <= 1'b1;
    end
  end

  // sink ready, with one long hold-off once the source runs without gaps
  initial begin : sink_ready
    logic hold_done;
    int   recv_idle;
    hold_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_phase == PH_FREE && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      case (idle_phase)
        PH_SLOW_SINK:   recv_idle = 60;
        PH_SLOW_SOURCE: recv_idle = 24;
        default:        recv_idle = 0;
      endcase
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // end of run
  initial begin : run_end
    wait (run_done || timed_out);
    if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!timed_out && error_count == 0 && pending_results.size() == 0) begin
      $display("sign_magnitude_alu_unit_test passed");
    end else begin
      $display("sign_magnitude_alu_unit_test failed");
    end
    $finish;
  end

endmodule
